// File: design/prp_pkg.sv
`timescale 1ns / 1ps
package prp_pkg;

   localparam int CoordBits   = 16;
   localparam int SizeBits    = CoordBits - 1;
   localparam int WideBits    = CoordBits + 4;
   localparam int OutBits     = CoordBits + 2;
   localparam int SelBits     = 4;
   localparam int AdjBits     = 6;
   localparam int CsrAddrBits = 3;
   localparam int PipeDepth   = 4;

   // adjust_mask bit positions
   localparam int AdjSlideX  = 0;
   localparam int AdjSlideY  = 1;
   localparam int AdjFlipX   = 2;
   localparam int AdjFlipY   = 3;
   localparam int AdjResizeX = 4;
   localparam int AdjResizeY = 5;

   typedef logic signed [WideBits-1:0] wide_type;
   typedef logic [1:0] part_idx_type;

   typedef enum logic [CsrAddrBits-1:0] {
      CSR_SCREEN_X  = 3'd0,
      CSR_SCREEN_Y  = 3'd1,
      CSR_SCREEN_W  = 3'd2,
      CSR_SCREEN_H  = 3'd3,
      CSR_PARENT_PT = 3'd4,
      CSR_CHILD_PT  = 3'd5,
      CSR_ADJUST    = 3'd6
   } csr_index_type;

   // one axis worth of candidate placements
   typedef struct packed {
      wide_type pos_plain;
      wide_type pos_flip;
      wide_type pos_slide;
      wide_type pos_rsz;
      wide_type size_plain;
      wide_type size_rsz;
   } axis_result_type;

   // column of a point code; unknown codes act as the upper-left corner
   function automatic part_idx_type sel_col(input logic [SelBits-1:0] s);
      part_idx_type r;
      unique case (s)
         4'd1, 4'd4, 4'd7: r = 2'd1;
         4'd2, 4'd5, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   // row of a point code; unknown codes act as the upper-left corner
   function automatic part_idx_type sel_row(input logic [SelBits-1:0] s);
      part_idx_type r;
      unique case (s)
         4'd3, 4'd4, 4'd5: r = 2'd1;
         4'd6, 4'd7, 4'd8: r = 2'd2;
         default:          r = 2'd0;
      endcase
      return r;
   endfunction

   // mirror an edge index, keep the middle
   function automatic part_idx_type flip_idx(input part_idx_type i);
      return 2'd2 - i;
   endfunction

   // offset of an edge or middle along a nonnegative size
   function automatic wide_type part(input part_idx_type i, input wide_type size);
      wide_type r;
      unique case (i)
         2'd0:    r = '0;
         2'd1:    r = size >>> 1;
         default: r = size;
      endcase
      return r;
   endfunction

   function automatic logic fit_axis(input wide_type pos, input wide_type size,
                                     input wide_type lo, input wide_type hi);
      return (pos >= lo) && (pos + size <= hi);
   endfunction

endpackage

// File: design/prp_axis.sv
`timescale 1ns / 1ps
module prp_axis (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [prp_pkg::CoordBits-1:0] a_pos,
   input  logic        [prp_pkg::SizeBits-1:0]  a_size,
   input  logic signed [prp_pkg::CoordBits-1:0] p_pos,
   input  logic        [prp_pkg::SizeBits-1:0]  p_size,
   input  logic        [prp_pkg::SizeBits-1:0]  c_size,
   input  logic signed [prp_pkg::CoordBits-1:0] shift,
   input  prp_pkg::part_idx_type                 par_idx,
   input  prp_pkg::part_idx_type                 chd_idx,
   input  prp_pkg::wide_type                     scr_lo,
   input  prp_pkg::wide_type                     scr_hi,
   input  logic                                  slide_en,
   input  logic                                  resize_en,
   output prp_pkg::axis_result_type              result
);

   // stage 1: anchor points and child offsets
   prp_pkg::wide_type pt_p_ff, pt_f_ff, plo_ff, phi_ff, cof_p_ff, cof_f_ff, csz1_ff;
   prp_pkg::wide_type pt_p_in, pt_f_in, plo_in, phi_in, cof_p_in, cof_f_in, csz1_in;
   prp_pkg::wide_type a_pos_w, a_size_w, c_size_w, shift_w;

   always_comb begin
      a_pos_w  = prp_pkg::WideBits'(a_pos);
      a_size_w = prp_pkg::wide_type'({{(prp_pkg::WideBits-prp_pkg::SizeBits){1'b0}}, a_size});
      c_size_w = prp_pkg::wide_type'({{(prp_pkg::WideBits-prp_pkg::SizeBits){1'b0}}, c_size});
      shift_w  = prp_pkg::WideBits'(shift);
      pt_p_in  = a_pos_w + prp_pkg::part(par_idx, a_size_w) + shift_w;
      pt_f_in  = a_pos_w + prp_pkg::part(prp_pkg::flip_idx(par_idx), a_size_w) - shift_w;
      plo_in   = prp_pkg::WideBits'(p_pos);
      phi_in   = prp_pkg::WideBits'(p_pos)
               + prp_pkg::wide_type'({{(prp_pkg::WideBits-prp_pkg::SizeBits){1'b0}}, p_size});
      cof_p_in = prp_pkg::part(chd_idx, c_size_w);
      cof_f_in = prp_pkg::part(prp_pkg::flip_idx(chd_idx), c_size_w);
      csz1_in  = c_size_w;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pt_p_ff  <= pt_p_in;
         pt_f_ff  <= pt_f_in;
         plo_ff   <= plo_in;
         phi_ff   <= phi_in;
         cof_p_ff <= cof_p_in;
         cof_f_ff <= cof_f_in;
         csz1_ff  <= csz1_in;
      end
   end

   // stage 2: clamp into parent, place child point
   prp_pkg::wide_type x_p_ff, x_f_ff, csz2_ff;
   prp_pkg::wide_type x_p_in, x_f_in, cl_p, cl_f;

   always_comb begin
      cl_p = (pt_p_ff < plo_ff) ? plo_ff : ((pt_p_ff > phi_ff) ? phi_ff : pt_p_ff);
      cl_f = (pt_f_ff < plo_ff) ? plo_ff : ((pt_f_ff > phi_ff) ? phi_ff : pt_f_ff);
      x_p_in = cl_p - cof_p_ff;
      x_f_in = cl_f - cof_f_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_p_ff  <= x_p_in;
         x_f_ff  <= x_f_in;
         csz2_ff <= csz1_ff;
      end
   end

   // stage 3: overhangs of the plain placement
   prp_pkg::wide_type lo_ff, hi_ff, x_p3_ff, x_f3_ff, csz3_ff;
   prp_pkg::wide_type lo_in, hi_in;

   always_comb begin
      lo_in = x_p_ff - scr_lo;
      hi_in = x_p_ff + csz2_ff - scr_hi;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         x_p3_ff <= x_p_ff;
         x_f3_ff <= x_f_ff;
         csz3_ff <= csz2_ff;
      end
   end

   // stage 4: slide and resize candidates
   prp_pkg::axis_result_type res_ff, res_in;
   logic neg_lo, pos_hi;

   always_comb begin
      neg_lo = lo_ff < 0;
      pos_hi = hi_ff > 0;
      res_in.pos_plain  = x_p3_ff;
      res_in.pos_flip   = x_f3_ff;
      res_in.size_plain = csz3_ff;
      if (!slide_en) begin
         res_in.pos_slide = x_p3_ff;
      end else if (neg_lo) begin
         res_in.pos_slide = scr_lo;
      end else if (pos_hi) begin
         res_in.pos_slide = x_p3_ff - hi_ff;
      end else begin
         res_in.pos_slide = x_p3_ff;
      end
      res_in.pos_rsz  = (resize_en && neg_lo) ? scr_lo : x_p3_ff;
      res_in.size_rsz = resize_en
                      ? csz3_ff + (neg_lo ? lo_ff : '0) - (pos_hi ? hi_ff : '0)
                      : csz3_ff;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

// File: design/prp_select.sv
`timescale 1ns / 1ps
module prp_select (
   input  logic                                clock,
   input  logic                                advance,
   input  prp_pkg::axis_result_type             ax,
   input  prp_pkg::axis_result_type             ay,
   input  prp_pkg::wide_type                    sx_lo,
   input  prp_pkg::wide_type                    sx_hi,
   input  prp_pkg::wide_type                    sy_lo,
   input  prp_pkg::wide_type                    sy_hi,
   input  logic                                 flip_x,
   input  logic                                 flip_y,
   output logic [4*prp_pkg::OutBits-1:0]        data
);

   logic fxp, fxf, fyp, fyf, f_slide, f_rsz;
   prp_pkg::wide_type px, py, pw, ph;
   logic [4*prp_pkg::OutBits-1:0] data_ff, data_in;

   // test every candidate, pick the first enabled one that fits, else the plain one
   always_comb begin
      fxp = prp_pkg::fit_axis(ax.pos_plain, ax.size_plain, sx_lo, sx_hi);
      fxf = prp_pkg::fit_axis(ax.pos_flip,  ax.size_plain, sx_lo, sx_hi);
      fyp = prp_pkg::fit_axis(ay.pos_plain, ay.size_plain, sy_lo, sy_hi);
      fyf = prp_pkg::fit_axis(ay.pos_flip,  ay.size_plain, sy_lo, sy_hi);
      f_slide = prp_pkg::fit_axis(ax.pos_slide, ax.size_plain, sx_lo, sx_hi)
             && prp_pkg::fit_axis(ay.pos_slide, ay.size_plain, sy_lo, sy_hi);
      f_rsz   = prp_pkg::fit_axis(ax.pos_rsz, ax.size_rsz, sx_lo, sx_hi)
             && prp_pkg::fit_axis(ay.pos_rsz, ay.size_rsz, sy_lo, sy_hi);
      pw = ax.size_plain;
      ph = ay.size_plain;
      priority if (fxp && fyp) begin
         px = ax.pos_plain;  py = ay.pos_plain;
      end else if (flip_x && fxf && fyp) begin
         px = ax.pos_flip;   py = ay.pos_plain;
      end else if (flip_y && fxp && fyf) begin
         px = ax.pos_plain;  py = ay.pos_flip;
      end else if (flip_x && flip_y && fxf && fyf) begin
         px = ax.pos_flip;   py = ay.pos_flip;
      end else if (f_slide) begin
         px = ax.pos_slide;  py = ay.pos_slide;
      end else if (f_rsz) begin
         px = ax.pos_rsz;    py = ay.pos_rsz;
         pw = ax.size_rsz;   ph = ay.size_rsz;
      end else begin
         px = ax.pos_plain;  py = ay.pos_plain;
      end
      data_in = {ph[prp_pkg::OutBits-1:0], pw[prp_pkg::OutBits-1:0],
                 py[prp_pkg::OutBits-1:0], px[prp_pkg::OutBits-1:0]};
   end

   // hold the result while the consumer stalls
   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= data_in;
      end
   end

   assign data = data_ff;

endmodule

// File: design/popup_rectangle_placer.sv
`timescale 1ns / 1ps
// Pipeline: four axis stages and the selection stage, which is also the output
// register.
// Throughput: one beat per cycle; the whole pipeline freezes while rsp is stalled.
// Reset (synchronous, active high) clears all valid bits and restores the
// registers: screen 0,0 1920x1080, point codes upper-left, adjust mask 0.
module popup_rectangle_placer (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // anchor_x, anchor_y, anchor_w, anchor_h, parent_x, parent_y, parent_w,
   // parent_h, child_w, child_h, shift_x, shift_y, zero pad
   input  logic [191:0]                          req_tdata,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // place_x, place_y, place_w, place_h
   output logic [4*prp_pkg::OutBits-1:0]         rsp_tdata,
   input  logic                                  csr_we,
   input  logic [prp_pkg::CsrAddrBits-1:0]       csr_addr,
   input  logic [prp_pkg::CoordBits-1:0]         csr_wdata
);

   // configuration registers
   logic signed [prp_pkg::CoordBits-1:0] scr_x_ff, scr_y_ff;
   logic [prp_pkg::SizeBits-1:0]         scr_w_ff, scr_h_ff;
   logic [prp_pkg::SelBits-1:0]          psel_ff, csel_ff;
   logic [prp_pkg::AdjBits-1:0]          adj_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         scr_x_ff <= '0;
         scr_y_ff <= '0;
         scr_w_ff <= prp_pkg::SizeBits'(1920);
         scr_h_ff <= prp_pkg::SizeBits'(1080);
         psel_ff  <= '0;
         csel_ff  <= '0;
         adj_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            prp_pkg::CSR_SCREEN_X:  scr_x_ff <= csr_wdata;
            prp_pkg::CSR_SCREEN_Y:  scr_y_ff <= csr_wdata;
            prp_pkg::CSR_SCREEN_W:  scr_w_ff <= csr_wdata[prp_pkg::SizeBits-1:0];
            prp_pkg::CSR_SCREEN_H:  scr_h_ff <= csr_wdata[prp_pkg::SizeBits-1:0];
            prp_pkg::CSR_PARENT_PT: psel_ff  <= csr_wdata[prp_pkg::SelBits-1:0];
            prp_pkg::CSR_CHILD_PT:  csel_ff  <= csr_wdata[prp_pkg::SelBits-1:0];
            prp_pkg::CSR_ADJUST:    adj_ff   <= csr_wdata[prp_pkg::AdjBits-1:0];
            default: ;
         endcase
      end
   end

   // screen bounds
   prp_pkg::wide_type sx_lo, sx_hi, sy_lo, sy_hi;
   always_comb begin
      sx_lo = prp_pkg::WideBits'(scr_x_ff);
      sy_lo = prp_pkg::WideBits'(scr_y_ff);
      sx_hi = sx_lo + prp_pkg::wide_type'({{(prp_pkg::WideBits-prp_pkg::SizeBits){1'b0}},
                                           scr_w_ff});
      sy_hi = sy_lo + prp_pkg::wide_type'({{(prp_pkg::WideBits-prp_pkg::SizeBits){1'b0}},
                                           scr_h_ff});
   end

   // pipeline advances unless the output beat is stalled
   logic advance;
   logic [prp_pkg::PipeDepth-1:0] vld_ff, vld_in;
   logic out_vld_ff, out_vld_in;

   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   always_comb begin
      vld_in     = {vld_ff[prp_pkg::PipeDepth-2:0], req_tvalid};
      out_vld_in = vld_ff[prp_pkg::PipeDepth-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         vld_ff     <= vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   prp_pkg::axis_result_type ax, ay;

   prp_axis u_axis_x (
      .clock     (clock),
      .advance   (advance),
      .a_pos     (req_tdata[15:0]),
      .a_size    (req_tdata[46:32]),
      .p_pos     (req_tdata[77:62]),
      .p_size    (req_tdata[108:94]),
      .c_size    (req_tdata[138:124]),
      .shift     (req_tdata[169:154]),
      .par_idx   (prp_pkg::sel_col(psel_ff)),
      .chd_idx   (prp_pkg::sel_col(csel_ff)),
      .scr_lo    (sx_lo),
      .scr_hi    (sx_hi),
      .slide_en  (adj_ff[prp_pkg::AdjSlideX]),
      .resize_en (adj_ff[prp_pkg::AdjResizeX]),
      .result    (ax)
   );

   prp_axis u_axis_y (
      .clock     (clock),
      .advance   (advance),
      .a_pos     (req_tdata[31:16]),
      .a_size    (req_tdata[61:47]),
      .p_pos     (req_tdata[93:78]),
      .p_size    (req_tdata[123:109]),
      .c_size    (req_tdata[153:139]),
      .shift     (req_tdata[185:170]),
      .par_idx   (prp_pkg::sel_row(psel_ff)),
      .chd_idx   (prp_pkg::sel_row(csel_ff)),
      .scr_lo    (sy_lo),
      .scr_hi    (sy_hi),
      .slide_en  (adj_ff[prp_pkg::AdjSlideY]),
      .resize_en (adj_ff[prp_pkg::AdjResizeY]),
      .result    (ay)
   );

   prp_select u_select (
      .clock   (clock),
      .advance (advance),
      .ax      (ax),
      .ay      (ay),
      .sx_lo   (sx_lo),
      .sx_hi   (sx_hi),
      .sy_lo   (sy_lo),
      .sy_hi   (sy_hi),
      .flip_x  (adj_ff[prp_pkg::AdjFlipX]),
      .flip_y  (adj_ff[prp_pkg::AdjFlipY]),
      .data    (rsp_tdata)
   );

   assign rsp_tvalid = out_vld_ff;

`ifndef NO_ASSERTIONS
   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("req_tready does not track output stall");

   a_accept_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> vld_ff[0])
      else $error("accepted beat lost at pipe entry");

   a_width_kept_without_resize: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !adj_ff[prp_pkg::AdjResizeX] |-> !rsp_tdata[3*prp_pkg::OutBits-1])
      else $error("negative width without resize");
`endif

endmodule

// File: tb/sv/prp_placement_checker.sv
`timescale 1ns / 1ps
module prp_placement_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [191:0]                    req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [4*prp_pkg::OutBits-1:0]   rsp_tdata,
   input  logic                            csr_we,
   input  logic [prp_pkg::CsrAddrBits-1:0] csr_addr,
   input  logic [prp_pkg::CoordBits-1:0]   csr_wdata,
   output int                              fail_count,
   output int                              pending
);

   // shadow copy of the placement registers
   longint scr_x, scr_y, scr_w, scr_h;
   logic [prp_pkg::SelBits-1:0] parent_pt, child_pt;
   logic [prp_pkg::AdjBits-1:0] adj;

   logic [4*prp_pkg::OutBits-1:0] placement_q[$];

   initial fail_count = 0;
   initial pending = 0;

   task automatic report_mismatch(input string field, input longint got, input longint want);
      $display("placement mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   function automatic int sel_norm(input logic [prp_pkg::SelBits-1:0] s);
      return (s > 8) ? 0 : int'(s);
   endfunction

   // mirror the column (flip x) or the row (flip y), middle stays
   function automatic int mirror_col(input int s);
      return s - (s % 3) + (2 - (s % 3));
   endfunction

   function automatic int mirror_row(input int s);
      return (2 - s / 3) * 3 + s % 3;
   endfunction

   function automatic longint offset_of(input int idx, input longint size);
      return idx == 0 ? 0 : (idx == 1 ? size / 2 : size);
   endfunction

   // one axis: anchor point plus shift, clamp into parent, subtract child point
   function automatic longint axis_pos(input longint a, input longint asz, input int pidx,
                                       input longint d, input longint p, input longint psz,
                                       input int cidx, input longint csz);
      longint v;
      v = a + offset_of(pidx, asz) + d;
      if (v < p) v = p;
      else if (v > p + psz) v = p + psz;
      return v - offset_of(cidx, csz);
   endfunction

   function automatic bit on_screen(input longint x, input longint y,
                                    input longint w, input longint h);
      return x >= scr_x && y >= scr_y && x + w <= scr_x + scr_w && y + h <= scr_y + scr_h;
   endfunction

   function automatic logic [4*prp_pkg::OutBits-1:0] predict_placement(input logic [191:0] d);
      longint ax, ay, aw, ah, px, py, pw, ph, cw, ch, dx, dy;
      longint bx, by, x, y, w, h, lo, hi;
      int ps, cs, tp, tc;
      bit fx, fy, ok;
      logic [prp_pkg::OutBits-1:0] ox, oy, ow, oh;
      ax = longint'($signed(d[15:0]));    ay = longint'($signed(d[31:16]));
      aw = longint'(d[46:32]);            ah = longint'(d[61:47]);
      px = longint'($signed(d[77:62]));   py = longint'($signed(d[93:78]));
      pw = longint'(d[108:94]);           ph = longint'(d[123:109]);
      cw = longint'(d[138:124]);          ch = longint'(d[153:139]);
      dx = longint'($signed(d[169:154])); dy = longint'($signed(d[185:170]));
      ps = sel_norm(parent_pt);
      cs = sel_norm(child_pt);
      fx = adj[prp_pkg::AdjFlipX];
      fy = adj[prp_pkg::AdjFlipY];
      bx = axis_pos(ax, aw, ps % 3, dx, px, pw, cs % 3, cw);
      by = axis_pos(ay, ah, ps / 3, dy, py, ph, cs / 3, ch);
      x = bx; y = by; w = cw; h = ch;
      ok = on_screen(x, y, w, h);
      if (!ok && fx) begin
         tp = mirror_col(ps); tc = mirror_col(cs);
         x = axis_pos(ax, aw, tp % 3, -dx, px, pw, tc % 3, cw);
         y = axis_pos(ay, ah, tp / 3, dy, py, ph, tc / 3, ch);
         ok = on_screen(x, y, w, h);
      end
      if (!ok && fy) begin
         tp = mirror_row(ps); tc = mirror_row(cs);
         x = axis_pos(ax, aw, tp % 3, dx, px, pw, tc % 3, cw);
         y = axis_pos(ay, ah, tp / 3, -dy, py, ph, tc / 3, ch);
         ok = on_screen(x, y, w, h);
      end
      if (!ok && fx && fy) begin
         tp = mirror_col(mirror_row(ps)); tc = mirror_col(mirror_row(cs));
         x = axis_pos(ax, aw, tp % 3, -dx, px, pw, tc % 3, cw);
         y = axis_pos(ay, ah, tp / 3, -dy, py, ph, tc / 3, ch);
         ok = on_screen(x, y, w, h);
      end
      // slide: left or top overhang wins over right or bottom
      if (!ok) begin
         x = bx; y = by; w = cw; h = ch;
         if (adj[prp_pkg::AdjSlideX]) begin
            lo = x - scr_x; hi = x + w - (scr_x + scr_w);
            if (lo < 0) x -= lo; else if (hi > 0) x -= hi;
         end
         if (adj[prp_pkg::AdjSlideY]) begin
            lo = y - scr_y; hi = y + h - (scr_y + scr_h);
            if (lo < 0) y -= lo; else if (hi > 0) y -= hi;
         end
         ok = on_screen(x, y, w, h);
      end
      // resize: both overhangs measured on the plain placement
      if (!ok) begin
         x = bx; y = by; w = cw; h = ch;
         if (adj[prp_pkg::AdjResizeX]) begin
            lo = x - scr_x; hi = x + w - (scr_x + scr_w);
            if (lo < 0) begin x -= lo; w += lo; end
            if (hi > 0) w -= hi;
         end
         if (adj[prp_pkg::AdjResizeY]) begin
            lo = y - scr_y; hi = y + h - (scr_y + scr_h);
            if (lo < 0) begin y -= lo; h += lo; end
            if (hi > 0) h -= hi;
         end
         ok = on_screen(x, y, w, h);
      end
      if (!ok) begin
         x = bx; y = by; w = cw; h = ch;
      end
      ox = x[prp_pkg::OutBits-1:0]; oy = y[prp_pkg::OutBits-1:0];
      ow = w[prp_pkg::OutBits-1:0]; oh = h[prp_pkg::OutBits-1:0];
      return {oh, ow, oy, ox};
   endfunction

   // track registers, queue predictions, compare results
   always @(posedge clock) begin
      logic [4*prp_pkg::OutBits-1:0] want;
      if (reset) begin
         scr_x <= 0; scr_y <= 0; scr_w <= 1920; scr_h <= 1080;
         parent_pt <= '0; child_pt <= '0; adj <= '0;
         placement_q.delete();
         pending <= 0;
      end else begin
         if (req_tvalid && req_tready)
            placement_q.push_back(predict_placement(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (placement_q.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               want = placement_q.pop_front();
               if (rsp_tdata[17:0] !== want[17:0])
                  report_mismatch("place_x", $signed(rsp_tdata[17:0]), $signed(want[17:0]));
               if (rsp_tdata[35:18] !== want[35:18])
                  report_mismatch("place_y", $signed(rsp_tdata[35:18]), $signed(want[35:18]));
               if (rsp_tdata[53:36] !== want[53:36])
                  report_mismatch("place_w", $signed(rsp_tdata[53:36]), $signed(want[53:36]));
               if (rsp_tdata[71:54] !== want[71:54])
                  report_mismatch("place_h", $signed(rsp_tdata[71:54]), $signed(want[71:54]));
            end
         end
         pending <= placement_q.size();
         if (csr_we) begin
            case (csr_addr)
               prp_pkg::CSR_SCREEN_X:  scr_x <= longint'($signed(csr_wdata));
               prp_pkg::CSR_SCREEN_Y:  scr_y <= longint'($signed(csr_wdata));
               prp_pkg::CSR_SCREEN_W:  scr_w <= longint'(csr_wdata[prp_pkg::SizeBits-1:0]);
               prp_pkg::CSR_SCREEN_H:  scr_h <= longint'(csr_wdata[prp_pkg::SizeBits-1:0]);
               prp_pkg::CSR_PARENT_PT: parent_pt <= csr_wdata[prp_pkg::SelBits-1:0];
               prp_pkg::CSR_CHILD_PT:  child_pt <= csr_wdata[prp_pkg::SelBits-1:0];
               prp_pkg::CSR_ADJUST:    adj <= csr_wdata[prp_pkg::AdjBits-1:0];
               default: ;
            endcase
         end
      end
   end

endmodule

// File: tb/sv/tb_popup_rectangle_placer.sv
`timescale 1ns / 1ps
module tb_popup_rectangle_placer;

   typedef struct {
      logic signed [15:0] ax, ay, px, py, dx, dy;
      logic [14:0]        aw, ah, pw, ph, cw, ch;
   } placement_req_type;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [191:0]                    req_tdata;
   logic                            rsp_tvalid;
   logic                            rsp_tready;
   logic [4*prp_pkg::OutBits-1:0]   rsp_tdata;
   logic                            csr_we;
   logic [prp_pkg::CsrAddrBits-1:0] csr_addr;
   logic [prp_pkg::CoordBits-1:0]   csr_wdata;
   int                              fail_count;
   int                              pending;

   // idling controls shared by sender and receiver
   bit steady;
   bit hold_rsp;

   popup_rectangle_placer i_dut (.*);

   prp_placement_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // receiver: random backpressure, with one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready = 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 1'b0;
         end
         rsp_tready = steady || ($urandom_range(99) >= 22);
      end
   end

   function automatic logic [191:0] pack_req(input placement_req_type r);
      return {6'd0, r.dy, r.dx, r.ch, r.cw, r.ph, r.pw, r.py, r.px, r.ah, r.aw, r.ay, r.ax};
   endfunction

   // place one beat on the request channel; called at a falling edge
   task automatic send_req(input placement_req_type r);
      if (!steady && $urandom_range(99) < 28) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = pack_req(r);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // drain the pipeline before touching registers
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_reg(input prp_pkg::csr_index_type idx, input logic [15:0] val);
      csr_we = 1'b1; csr_addr = idx; csr_wdata = val;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic write_all(input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sw,
                            input logic [15:0] sh, input logic [15:0] psel,
                            input logic [15:0] csel, input logic [15:0] adjm);
      drain();
      write_reg(prp_pkg::CSR_SCREEN_X, sx);
      write_reg(prp_pkg::CSR_SCREEN_Y, sy);
      write_reg(prp_pkg::CSR_SCREEN_W, sw);
      write_reg(prp_pkg::CSR_SCREEN_H, sh);
      write_reg(prp_pkg::CSR_PARENT_PT, psel);
      write_reg(prp_pkg::CSR_CHILD_PT, csel);
      write_reg(prp_pkg::CSR_ADJUST, adjm);
   endtask

   // mostly near-screen geometry so flips, slides and resizes trigger
   function automatic placement_req_type rand_req();
      placement_req_type r;
      if ($urandom_range(99) < 20) begin
         r.ax = 16'($urandom); r.ay = 16'($urandom);
         r.px = 16'($urandom); r.py = 16'($urandom);
         r.dx = 16'($urandom); r.dy = 16'($urandom);
         r.aw = 15'($urandom); r.ah = 15'($urandom);
         r.pw = 15'($urandom); r.ph = 15'($urandom);
         r.cw = 15'($urandom); r.ch = 15'($urandom);
      end else begin
         r.ax = 16'($signed($urandom_range(2400)) - 200);
         r.ay = 16'($signed($urandom_range(1400)) - 200);
         r.aw = 15'($urandom_range(400));
         r.ah = 15'($urandom_range(300));
         r.px = 16'($signed($urandom_range(600)) - 300);
         r.py = 16'($signed($urandom_range(600)) - 300);
         r.pw = 15'($urandom_range(2600));
         r.ph = 15'($urandom_range(1600));
         r.cw = 15'($urandom_range(1200));
         r.ch = 15'($urandom_range(800));
         r.dx = 16'($signed($urandom_range(600)) - 300);
         r.dy = 16'($signed($urandom_range(600)) - 300);
      end
      return r;
   endfunction

   function automatic placement_req_type fill_req(input logic [15:0] s, input logic [14:0] u);
      placement_req_type r;
      r.ax = s; r.ay = s; r.px = s; r.py = s; r.dx = s; r.dy = s;
      r.aw = u; r.ah = u; r.pw = u; r.ph = u; r.cw = u; r.ch = u;
      return r;
   endfunction

   initial begin
      placement_req_type r;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_addr   = prp_pkg::CSR_SCREEN_X;
      csr_wdata  = '0;
      steady     = 1'b0;
      hold_rsp   = 1'b0;
      reset      = 1'b1;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // directed: field extremes at reset settings
      send_req(fill_req(16'h8000, 15'h0000));
      send_req(fill_req(16'h7fff, 15'h7fff));
      send_req(fill_req(16'h0000, 15'h7fff));
      send_req(fill_req(16'hffff, 15'h0001));
      // each point paired with its mirror, all adjustments, child overhanging each edge
      for (int i = 0; i < 9; i++) begin
         write_all(16'd0, 16'd0, 16'd1920, 16'd1080, 16'(i), 16'(8 - i), 16'd63);
         r = fill_req(16'd0, 15'd0);
         r.ax = 1800; r.ay = 1000; r.aw = 100; r.ah = 60; r.pw = 4000; r.ph = 3000;
         r.cw = 300; r.ch = 200; r.dx = 10; r.dy = -5;
         send_req(r);
         r.ax = -40; r.ay = -30; r.cw = 2500; r.ch = 1500;
         send_req(r);
      end
      // unknown point codes act as upper-left
      write_all(16'd0, 16'd0, 16'd1920, 16'd1080, 16'd15, 16'd9, 16'd12);
      send_req(rand_req());
      send_req(rand_req());

      // random phases, extremes included
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: write_all(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 16'd4, 16'd4, 16'd63);
            1: write_all(16'h7fff, 16'h7fff, 16'h0000, 16'h0000, 16'd8, 16'd0, 16'd0);
            2: write_all(16'd0, 16'd0, 16'd0, 16'd0, 16'd2, 16'd6, 16'd48);
            default: write_all(16'($signed($urandom_range(400)) - 200),
                               16'($signed($urandom_range(400)) - 200),
                               16'($urandom_range(2400, 200)),
                               16'($urandom_range(1600, 200)),
                               16'($urandom_range(15)), 16'($urandom_range(15)),
                               16'($urandom_range(63)));
         endcase
         steady = (ph == 4);
         for (int n = 0; n < 100; n++) begin
            if (ph == 6 && n == 10) hold_rsp = 1'b1;
            send_req(rand_req());
         end
         steady = 1'b0;
      end

      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: files.f
design/prp_pkg.sv
design/prp_axis.sv
design/prp_select.sv
design/popup_rectangle_placer.sv
tb/sv/prp_placement_checker.sv
tb/sv/tb_popup_rectangle_placer.sv
